FILE: rtl/core/wshp_pkg.sv
package wshp_pkg;

  localparam logic [3:0] POS_FIRST  = 4'd0;
  localparam logic [3:0] POS_SECOND = 4'd1;

  localparam logic [6:0] LEN16_CODE = 7'd126;
  localparam logic [6:0] LEN64_CODE = 7'd127;

  localparam logic [3:0] EXT_NONE  = 4'd0;
  localparam logic [3:0] EXT_LEN16 = 4'd2;
  localparam logic [3:0] EXT_LEN64 = 4'd8;

  localparam logic [3:0] HDR_BASE  = 4'd2;
  localparam logic [3:0] KEY_BYTES = 4'd4;

  localparam logic [63:0] CTRL_MAX_LEN = 64'd125;
  localparam logic [63:0] LEN16_MIN    = 64'd126;
  localparam logic [63:0] LEN16_MAX    = 64'h0000_0000_0000_ffff;

  localparam logic [3:0] OP_CONT  = 4'h0;
  localparam logic [3:0] OP_TEXT  = 4'h1;
  localparam logic [3:0] OP_BIN   = 4'h2;
  localparam logic [3:0] OP_CLOSE = 4'h8;
  localparam logic [3:0] OP_PING  = 4'h9;
  localparam logic [3:0] OP_PONG  = 4'ha;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  typedef struct packed {
    logic [3:0]  pos;
    logic [7:0]  first;
    logic [7:0]  second;
    logic [63:0] len;
    logic [31:0] key;
  } parse_state_t;

  typedef struct packed {
    logic        status;
    logic        fin;
    logic [3:0]  frame_opcode;
    logic        masked;
    logic [62:0] payload_length;
    logic [31:0] mask_word;
    logic [3:0]  header_bytes;
  } result_t;

endpackage

FILE: rtl/core/wshp_if.sv
interface wshp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] header_byte;
  logic       restart;

  modport source (output valid, output header_byte, output restart, input ready);
  modport sink   (input valid, input header_byte, input restart, output ready);
endinterface

interface wshp_out_if;
  logic        valid;
  logic        ready;
  logic        status;
  logic        fin;
  logic [3:0]  frame_opcode;
  logic        masked;
  logic [62:0] payload_length;
  logic [31:0] mask_word;
  logic [3:0]  header_bytes;

  modport source (output valid, output status, output fin, output frame_opcode,
                  output masked, output payload_length, output mask_word,
                  output header_bytes, input ready);
  modport sink   (input valid, input status, input fin, input frame_opcode,
                  input masked, input payload_length, input mask_word,
                  input header_bytes, output ready);
endinterface

FILE: rtl/core/wshp_step.sv
module wshp_step
  import wshp_pkg::*;
(
  input  parse_state_t st,
  input  logic [7:0]   hdr_byte,
  input  logic         restart,
  output parse_state_t st_nxt,
  output logic         emit,
  output result_t      res
);

  logic [3:0]  pos;
  logic [6:0]  code;
  logic [3:0]  ext;
  logic [3:0]  len_end;
  logic        msk;
  logic        fail;
  logic        fin_req;
  logic [3:0]  fin_hdr;
  logic        len_bad;
  logic [3:0]  op;
  logic        ctrl_bad;
  logic        op_bad;
  logic        err;

  always_comb begin
    pos      = restart ? POS_FIRST : st.pos;
    st_nxt   = st;
    fail     = 1'b0;
    fin_req  = 1'b0;
    fin_hdr  = HDR_BASE;
    len_bad  = 1'b0;
    code     = st.second[6:0];
    ext      = (code == LEN16_CODE) ? EXT_LEN16 :
               (code == LEN64_CODE) ? EXT_LEN64 : EXT_NONE;
    len_end  = HDR_BASE + ext;
    msk      = st.second[7];
    case (pos)
      POS_FIRST: begin
        st_nxt.first  = hdr_byte;
        st_nxt.second = 8'd0;
        st_nxt.len    = 64'd0;
        st_nxt.key    = 32'd0;
        st_nxt.pos    = POS_SECOND;
      end
      POS_SECOND: begin
        st_nxt.second = hdr_byte;
        if (st.first[6:4] != 3'd0) begin
          fail = 1'b1;
        end else begin
          if (hdr_byte[6:0] < LEN16_CODE) begin
            st_nxt.len = {57'd0, hdr_byte[6:0]};
          end
          if (hdr_byte[6:0] < LEN16_CODE && !hdr_byte[7]) begin
            fin_req = 1'b1;
            fin_hdr = HDR_BASE;
          end else begin
            st_nxt.pos = pos + 4'd1;
          end
        end
      end
      default: begin
        if (pos < len_end) begin
          st_nxt.len = {st.len[55:0], hdr_byte};
          if (pos == len_end - 4'd1) begin
            if (code == LEN16_CODE) begin
              len_bad = st_nxt.len < LEN16_MIN;
            end else begin
              len_bad = st_nxt.len[63] || (st_nxt.len <= LEN16_MAX);
            end
            if (len_bad) begin
              fail = 1'b1;
            end else if (!msk) begin
              fin_req = 1'b1;
              fin_hdr = len_end;
            end else begin
              st_nxt.pos = pos + 4'd1;
            end
          end else begin
            st_nxt.pos = pos + 4'd1;
          end
        end else begin
          st_nxt.key = {st.key[23:0], hdr_byte};
          if (pos >= len_end + 4'd3) begin
            fin_req = 1'b1;
            fin_hdr = len_end + KEY_BYTES;
          end else begin
            st_nxt.pos = pos + 4'd1;
          end
        end
      end
    endcase

    // final checks on a complete header
    op       = st_nxt.first[3:0];
    ctrl_bad = op[3] && (!st_nxt.first[7] || (st_nxt.len > CTRL_MAX_LEN));
    op_bad   = !(op inside {OP_CONT, OP_TEXT, OP_BIN, OP_CLOSE, OP_PING, OP_PONG});
    err      = fail || (fin_req && (ctrl_bad || op_bad));
    emit     = fail || fin_req;
    if (emit) begin
      st_nxt.pos = POS_FIRST;
    end

    res.status         = err ? STATUS_ERR : STATUS_OK;
    res.fin            = st_nxt.first[7];
    res.frame_opcode   = op;
    res.masked         = st_nxt.second[7];
    res.payload_length = err ? 63'd0 : st_nxt.len[62:0];
    res.mask_word      = (err || !st_nxt.second[7]) ? 32'd0 : st_nxt.key;
    res.header_bytes   = err ? 4'd0 : fin_hdr;
  end

endmodule

FILE: rtl/core/websocket_header_parser.sv
// WebSocket (RFC 6455) frame header parser. Header bytes enter one per transfer on in_ch,
// with restart marking a byte as the first of a new header. Exactly one result leaves on
// out_ch per header, in the cycle after the byte that completes it (ok) or first breaks a rule
// (error: reserved bits, non-minimal 16/64-bit length, 64-bit top bit, bad control frame,
// illegal opcode); error results carry fin, opcode and mask bit with zero length, key and
// size. One byte is taken every cycle unless in_ch stalls; the single output register holds a
// result until it is taken, and in_ch stalls only while it is full and out_ch is not ready.
module websocket_header_parser
  import wshp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  wshp_in_if.sink    in_ch,
  wshp_out_if.source out_ch
);

  parse_state_t st_r;
  parse_state_t st_nxt;
  result_t      res_nxt;
  result_t      res_r;
  logic         emit;
  logic         out_valid_r;
  logic         in_xfer;

  wshp_step u_step (
    .st       (st_r),
    .hdr_byte (in_ch.header_byte),
    .restart  (in_ch.restart),
    .st_nxt   (st_nxt),
    .emit     (emit),
    .res      (res_nxt)
  );

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_xfer     = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_xfer) begin
        st_r        <= st_nxt;
        out_valid_r <= emit;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && emit) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.status         = res_r.status;
  assign out_ch.fin            = res_r.fin;
  assign out_ch.frame_opcode   = res_r.frame_opcode;
  assign out_ch.masked         = res_r.masked;
  assign out_ch.payload_length = res_r.payload_length;
  assign out_ch.mask_word      = res_r.mask_word;
  assign out_ch.header_bytes   = res_r.header_bytes;

endmodule

FILE: rtl/core/wshp_checker.sv
module wshp_checker
  import wshp_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        status,
  input logic        fin,
  input logic [3:0]  frame_opcode,
  input logic        masked,
  input logic [62:0] payload_length,
  input logic [31:0] mask_word,
  input logic [3:0]  header_bytes
);

  logic ok_out;
  assign ok_out = out_valid && (status == STATUS_OK);

  // stalled result stays offered
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // input stalls only behind a full, stalled output register
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without cause");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status == STATUS_ERR) |->
      payload_length == 63'd0 && mask_word == 32'd0 && header_bytes == 4'd0)
    else $error("error result carries length, key or size");

  a_hdr_size: assert property (@(posedge clk) disable iff (!rst_n)
    ok_out |-> (header_bytes == 4'd2 && !masked) || (header_bytes == 4'd4 && !masked) ||
               (header_bytes == 4'd10 && !masked) || (header_bytes == 4'd6 && masked) ||
               (header_bytes == 4'd8 && masked) || (header_bytes == 4'd14 && masked))
    else $error("header size does not match mask bit");

  a_ctrl: assert property (@(posedge clk) disable iff (!rst_n)
    ok_out && frame_opcode[3] |-> fin && payload_length <= 63'd125 &&
                                  header_bytes != 4'd10)
    else $error("control frame passed with bad fin or length");

endmodule

bind websocket_header_parser wshp_checker u_wshp_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .status         (out_ch.status),
  .fin            (out_ch.fin),
  .frame_opcode   (out_ch.frame_opcode),
  .masked         (out_ch.masked),
  .payload_length (out_ch.payload_length),
  .mask_word      (out_ch.mask_word),
  .header_bytes   (out_ch.header_bytes)
);
